### sv/brsr_pkg.sv
// brsr_pkg: shared constants and types of the bilinear RGBA resampler.
// No dependencies; compile before every other file of the block.
package brsr_pkg;

    localparam int FRAC_BITS = 14;   // fractional bits used, 7..14 with 14-bit ports
    localparam int FRAC_W    = 14;   // width of the frac_x / frac_y fields
    localparam int WGT_W     = 7;    // interpolation weight width
    localparam int BYTE_W    = 8;
    localparam int LANES     = 4;    // byte channels per pixel
    localparam int PIX_W     = LANES * BYTE_W;
    localparam int SHINE_W   = 7;
    localparam int ALPHA_LANE = LANES - 1;  // byte 3 gets no shine

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [WGT_W-1:0]  wgt_t;
    typedef logic [SHINE_W-1:0] shine_t;

    // Values that travel with an item from the horizontal stage to the vertical one
    typedef struct packed {
        wgt_t wy;
        logic shine_on;
    } brsr_vctrl_t;

endpackage

### sv/brsr_if.sv
// brsr_if: valid/ready channel interfaces of the resampler (input, result, config).
// Depends on brsr_pkg.
interface brsr_in_if;
    logic                           valid;
    logic                           ready;
    logic [brsr_pkg::PIX_W-1:0]     top_left_pixel;
    logic [brsr_pkg::PIX_W-1:0]     top_right_pixel;
    logic [brsr_pkg::PIX_W-1:0]     bottom_left_pixel;
    logic [brsr_pkg::PIX_W-1:0]     bottom_right_pixel;
    logic [brsr_pkg::FRAC_W-1:0]    frac_x;
    logic [brsr_pkg::FRAC_W-1:0]    frac_y;
    logic [brsr_pkg::SHINE_W-1:0]   shine;
    logic                           row_end;

    modport source (
        output valid, top_left_pixel, top_right_pixel, bottom_left_pixel,
               bottom_right_pixel, frac_x, frac_y, shine, row_end,
        input  ready
    );
    modport sink (
        input  valid, top_left_pixel, top_right_pixel, bottom_left_pixel,
               bottom_right_pixel, frac_x, frac_y, shine, row_end,
        output ready
    );
endinterface

interface brsr_out_if;
    logic                       valid;
    logic                       ready;
    logic [brsr_pkg::PIX_W-1:0] pixel_out;
    logic                       row_end_out;

    modport source (output valid, pixel_out, row_end_out, input ready);
    modport sink   (input valid, pixel_out, row_end_out, output ready);
endinterface

interface brsr_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### sv/brsr_lane.sv
// brsr_lane: one byte channel; horizontal lerps, stage register, vertical lerp and shine.
// Depends on brsr_pkg.
module brsr_lane (
    input  logic                  clk,
    input  logic                  load,
    input  brsr_pkg::byte_t       tl,
    input  brsr_pkg::byte_t       tr,
    input  brsr_pkg::byte_t       bl,
    input  brsr_pkg::byte_t       br,
    input  brsr_pkg::wgt_t        wx,
    input  brsr_pkg::brsr_vctrl_t vctrl,
    input  brsr_pkg::shine_t      shine_add,
    output brsr_pkg::byte_t       result
);

    localparam logic [brsr_pkg::WGT_W:0] ONE = {1'b1, {brsr_pkg::WGT_W{1'b0}}};
    localparam int PROD_W = brsr_pkg::BYTE_W + brsr_pkg::WGT_W + 1;
    localparam logic [brsr_pkg::WGT_W-1:0] SAT = {brsr_pkg::WGT_W{1'b1}};

    // floor((a*(128-w) + b*w) / 128)
    function automatic brsr_pkg::byte_t lerp(input brsr_pkg::byte_t a,
                                             input brsr_pkg::byte_t b,
                                             input brsr_pkg::wgt_t w);
        logic [brsr_pkg::WGT_W:0] wa;
        logic [PROD_W-1:0]        acc;
        wa  = ONE - {1'b0, w};
        acc = PROD_W'(a) * PROD_W'(wa) + PROD_W'(b) * PROD_W'(w);
        return acc[brsr_pkg::WGT_W +: brsr_pkg::BYTE_W];
    endfunction

    brsr_pkg::byte_t top_reg, bot_reg;
    brsr_pkg::byte_t vert;
    logic [brsr_pkg::WGT_W:0] sum;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            top_reg <= lerp(tl, tr, wx);
            bot_reg <= lerp(bl, br, wx);
        end
    end

    always_comb
    begin
        vert = lerp(top_reg, bot_reg, vctrl.wy);
        sum  = {1'b0, vert[brsr_pkg::BYTE_W-1:1]}
             + {2'b00, shine_add[brsr_pkg::SHINE_W-1:1]};
        if (!vctrl.shine_on)
            result = vert;
        else if (sum > {1'b0, SAT})
            result = {SAT, 1'b0};
        else
            result = {sum[brsr_pkg::WGT_W-1:0], 1'b0};
    end

endmodule

### sv/brsr_merge.sv
// brsr_merge: packs the lane bytes into one pixel and applies the quality mode.
// Depends on brsr_pkg.
module brsr_merge (
    input  brsr_pkg::byte_t           lane_bytes [brsr_pkg::LANES],
    input  logic                      high_quality,
    input  logic [brsr_pkg::PIX_W-1:0] nearest,
    output logic [brsr_pkg::PIX_W-1:0] pixel
);

    logic [brsr_pkg::PIX_W-1:0] packed_pix;

    always_comb
    begin
        for (int i = 0; i < brsr_pkg::LANES; i++)
            packed_pix[i*brsr_pkg::BYTE_W +: brsr_pkg::BYTE_W] = lane_bytes[i];
        pixel = high_quality ? packed_pix : nearest;
    end

endmodule

### sv/bilinear_rgba_resample_shine.sv
// bilinear_rgba_resample_shine: top level of the bilinear RGBA resampler.
// Depends on brsr_pkg, brsr_if, brsr_lane and brsr_merge.
//
// One target pixel per clock, sustained: a beat is taken every cycle while the
// result side keeps up. Each beat passes two register stages: the first, in
// the four byte lanes, holds the horizontal interpolation of each byte (an
// 8x8 multiply pair per row); the second holds the vertical
// interpolation plus shine of each of the four lanes, as packed by
// the merge stage into the output register. Each stage has its own valid
// bit and stalls only when the one after it is full, so bubbles close up
// under back-pressure. The high_quality register (reset 1) selects bilinear
// with shine; 0 passes the top-left pixel unchanged. Write it only while the
// block is empty; its write channel is always ready.
module bilinear_rgba_resample_shine (
    input  logic         clk,
    input  logic         rst_n,
    brsr_in_if.sink      pix_in,
    brsr_out_if.source   pix_out,
    brsr_cfg_if.sink     cfg
);

    localparam int WGT_LSB = brsr_pkg::FRAC_BITS - brsr_pkg::WGT_W;

    // Weight is the top seven of the FRAC_BITS used bits
    function automatic brsr_pkg::wgt_t weight(input logic [brsr_pkg::FRAC_W-1:0] frac);
        return frac[WGT_LSB +: brsr_pkg::WGT_W];
    endfunction

    // Configuration
    logic high_quality_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            high_quality_reg <= 1'b1;
        else if (cfg.valid)
            high_quality_reg <= cfg.data;
    end

    // Stage control: each stage advances when the one after it has room
    logic valid_a_reg, valid_b_reg;
    logic ready_a, ready_b;
    logic load_a, load_b;

    assign ready_b      = !valid_b_reg || pix_out.ready;
    assign ready_a      = !valid_a_reg || ready_b;
    assign pix_in.ready = ready_a;
    assign load_a       = pix_in.valid && ready_a;
    assign load_b       = valid_a_reg && ready_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                valid_a_reg <= pix_in.valid;
            if (ready_b)
                valid_b_reg <= valid_a_reg;
        end
    end

    // Stage A side-band: hold what the vertical step and the merge need
    brsr_pkg::brsr_vctrl_t      vctrl_reg;
    brsr_pkg::shine_t           shine_reg;
    logic [brsr_pkg::PIX_W-1:0] nearest_reg;
    logic                       row_end_a_reg;

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            vctrl_reg.wy       <= weight(pix_in.frac_y);
            vctrl_reg.shine_on <= (pix_in.shine != '0);
            shine_reg          <= pix_in.shine;
            nearest_reg        <= pix_in.top_left_pixel;
            row_end_a_reg      <= pix_in.row_end;
        end
    end

    // Byte lanes; the alpha lane gets zero shine added
    brsr_pkg::wgt_t  wx;
    brsr_pkg::byte_t lane_bytes [brsr_pkg::LANES];

    assign wx = weight(pix_in.frac_x);

    for (genvar g = 0; g < brsr_pkg::LANES; g++)
    begin : g_lane
        brsr_lane u_lane (
            .clk       (clk),
            .load      (load_a),
            .tl        (pix_in.top_left_pixel[g*brsr_pkg::BYTE_W +: brsr_pkg::BYTE_W]),
            .tr        (pix_in.top_right_pixel[g*brsr_pkg::BYTE_W +: brsr_pkg::BYTE_W]),
            .bl        (pix_in.bottom_left_pixel[g*brsr_pkg::BYTE_W +: brsr_pkg::BYTE_W]),
            .br        (pix_in.bottom_right_pixel[g*brsr_pkg::BYTE_W +: brsr_pkg::BYTE_W]),
            .wx        (wx),
            .vctrl     (vctrl_reg),
            .shine_add ((g == brsr_pkg::ALPHA_LANE) ? '0 : shine_reg),
            .result    (lane_bytes[g])
        );
    end

    // Merge and output register
    logic [brsr_pkg::PIX_W-1:0] merged;
    logic [brsr_pkg::PIX_W-1:0] pixel_reg;
    logic                       row_end_b_reg;

    brsr_merge u_merge (
        .lane_bytes   (lane_bytes),
        .high_quality (high_quality_reg),
        .nearest      (nearest_reg),
        .pixel        (merged)
    );

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            pixel_reg     <= merged;
            row_end_b_reg <= row_end_a_reg;
        end
    end

    assign pix_out.valid       = valid_b_reg;
    assign pix_out.pixel_out   = pixel_reg;
    assign pix_out.row_end_out = row_end_b_reg;

endmodule

### sv/brsr_checker.sv
// brsr_checker: port-level assertions on the resampler, bound to its top level.
// Depends on brsr_pkg, bilinear_rgba_resample_shine and its channel interfaces.
module brsr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [brsr_pkg::PIX_W-1:0] pixel_out,
    input logic                       row_end_out
);

    // Beats taken but not yet delivered
    logic [1:0] inflight_reg, inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(row_end_out))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 2'd0)
        else $error("result without an accepted beat");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more beats in flight than pipeline stages");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == 2'd2 && !out_ready |-> !in_ready)
        else $error("input taken while pipeline full and stalled");

endmodule

bind bilinear_rgba_resample_shine brsr_checker u_brsr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pix_in.valid),
    .in_ready    (pix_in.ready),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .pixel_out   (pix_out.pixel_out),
    .row_end_out (pix_out.row_end_out)
);
